>>> rtl/svahr_pkg.sv
package svahr_pkg;

    // command codes
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd4;

    localparam int CFG_DATA_W = 24;
    localparam int LEN_W      = 20;
    localparam int GAIN_W     = 24;
    localparam int STEP_IN_W  = 32;
    localparam int QUARTER_W  = 31;

    localparam logic [GAIN_W-1:0] GAIN_FULL = 24'h800000;
    localparam logic [LEN_W-1:0]  CNT_MAX   = 20'hFFFFF;

    // pi/2 in q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // register reset values
    localparam logic [LEN_W-1:0]  ATTACK_LEN_RST   = 20'd240;
    localparam logic [LEN_W-1:0]  HOLD_LEN_RST     = 20'd0;
    localparam logic [LEN_W-1:0]  RELEASE_LEN_RST  = 20'd14400;
    localparam logic [GAIN_W-1:0] ATTACK_STEP_RST  = 24'd34953;
    localparam logic [GAIN_W-1:0] RELEASE_STEP_RST = 24'd583;

endpackage

>>> rtl/svahr_in_if.sv
interface svahr_in_if;
    import svahr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [STEP_IN_W-1:0] phase_step;

    modport source (output valid, output command, output phase_step, input ready);
    modport sink (input valid, input command, input phase_step, output ready);
endinterface

>>> rtl/svahr_out_if.sv
interface svahr_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           finished;

    modport source (output valid, output sample, output finished, input ready);
    modport sink (input valid, input sample, input finished, output ready);
endinterface

>>> rtl/svahr_cfg_if.sv
interface svahr_cfg_if;
    import svahr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sine_voice_with_ahr_envelope.sv
// path: an accepted tick item goes through the stage 1, stage 2, stage 3 and output
//   registers to audio (envelope/phase register, table read, multiply, rounding)
// throughput: one item per cycle while audio takes samples; four register stages
//   close up bubbles, so items are taken while a sample waits until all are full
// reset: asynchronous, active low; voice idle and silent, registers at defaults
module sine_voice_with_ahr_envelope #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16,
    parameter int PHASE_WIDTH      = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    svahr_in_if.sink     events,
    svahr_out_if.source  audio,
    svahr_cfg_if.sink    cfg
);
    import svahr_pkg::*;

    localparam int AW       = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W    = AW + 2;
    localparam int PROD_W   = QUARTER_W + GAIN_W;
    localparam int SHIFT    = PROD_W - SAMPLE_WIDTH;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SHIFT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATTACK,
        ST_HOLD,
        ST_RELEASE,
        ST_DONE
    } env_stage_t;

    // quarter-wave sine table in q30, sampled at bin centers, built at elaboration
    // from a truncated taylor series up to x^11
    logic [QUARTER_W-1:0] quarter_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] X  = (PI_HALF_Q30 * 64'(2 * k + 1)) /
                                     64'(2 * SINE_TABLE_DEPTH);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] S  = X - T1 + T2 - T3 + T4 - T5;
        assign quarter_rom[k] = S[QUARTER_W-1:0];
    end

    // configuration registers
    logic [LEN_W-1:0]  attack_len_reg;
    logic [LEN_W-1:0]  hold_len_reg;
    logic [LEN_W-1:0]  release_len_reg;
    logic [GAIN_W-1:0] attack_step_reg;
    logic [GAIN_W-1:0] release_step_reg;

    // voice state
    env_stage_t             stage_reg, stage_next;
    logic [PHASE_WIDTH-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_WIDTH-1:0] step_reg, step_next;
    logic [LEN_W-1:0]       elapsed_reg, elapsed_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic                   released_reg, released_next;

    // stage 1: table index and gain of the sample
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [GAIN_W-1:0] s1_gain_reg;
    logic             s1_fin_reg;
    // stage 2: table magnitude
    logic                 s2_valid_reg;
    logic [QUARTER_W-1:0] s2_mag_reg;
    logic                 s2_neg_reg;
    logic [GAIN_W-1:0]    s2_gain_reg;
    logic                 s2_fin_reg;
    // stage 3: product
    logic              s3_valid_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic              s3_neg_reg;
    logic              s3_fin_reg;
    // output register
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_fin_reg;

    // pipeline flow: a stage loads when it is empty or the one after it moves on
    logic take_out, take3, take2, take1;
    logic in_fire, tick_fire;

    assign take_out = !out_valid_reg || audio.ready;
    assign take3    = !s3_valid_reg || take_out;
    assign take2    = !s2_valid_reg || take3;
    assign take1    = !s1_valid_reg || take2;

    assign events.ready = take1;
    assign cfg.ready    = 1'b1;
    assign in_fire      = events.valid && events.ready;
    assign tick_fire    = in_fire && (events.command == CMD_TICK);

    // envelope step for a tick
    logic              voice_active;
    logic              hold_done;
    env_stage_t        stage_use;
    logic [LEN_W-1:0]  elapsed_use;
    logic [GAIN_W-1:0] gain_use;
    logic [LEN_W-1:0]  elapsed_inc;
    logic [GAIN_W:0]   attack_sum;
    logic [GAIN_W-1:0] sample_gain;

    assign voice_active = (stage_reg != ST_IDLE) && (stage_reg != ST_DONE);
    // release waits for note off and the minimum hold
    assign hold_done    = (stage_reg == ST_HOLD) && released_reg &&
                          (elapsed_reg >= hold_len_reg);
    assign stage_use    = hold_done ? ST_RELEASE : stage_reg;
    assign elapsed_use  = hold_done ? '0 : elapsed_reg;
    assign gain_use     = hold_done ? GAIN_FULL : gain_reg;
    // elapsed count saturates
    assign elapsed_inc  = (elapsed_use == CNT_MAX) ? elapsed_use : elapsed_use + 1'b1;
    assign attack_sum   = {1'b0, gain_use} + {1'b0, attack_step_reg};
    // idle and finished voices are silent
    assign sample_gain  = voice_active ? gain_use : '0;

    always_comb
    begin
        stage_next     = stage_reg;
        phase_acc_next = phase_acc_reg;
        step_next      = step_reg;
        elapsed_next   = elapsed_reg;
        gain_next      = gain_reg;
        released_next  = released_reg;
        if (in_fire)
        begin
            case (events.command)
                CMD_NOTE_ON:
                begin
                    // restart from the attack, even mid note
                    stage_next     = ST_ATTACK;
                    phase_acc_next = '0;
                    step_next      = PHASE_WIDTH'(events.phase_step);
                    elapsed_next   = '0;
                    gain_next      = '0;
                    released_next  = 1'b0;
                end
                CMD_NOTE_OFF:
                begin
                    released_next = 1'b1;
                end
                CMD_TICK:
                begin
                    if (voice_active)
                    begin
                        phase_acc_next = phase_acc_reg + step_reg;
                        stage_next     = stage_use;
                        elapsed_next   = elapsed_inc;
                        gain_next      = gain_use;
                        case (stage_use)
                            ST_ATTACK:
                            begin
                                gain_next = (attack_sum > {1'b0, GAIN_FULL}) ?
                                            GAIN_FULL : attack_sum[GAIN_W-1:0];
                                if (elapsed_inc >= attack_len_reg)
                                begin
                                    gain_next    = GAIN_FULL;
                                    stage_next   = ST_HOLD;
                                    elapsed_next = '0;
                                end
                            end
                            ST_RELEASE:
                            begin
                                gain_next = (gain_use > release_step_reg) ?
                                            gain_use - release_step_reg : '0;
                                if (elapsed_inc >= release_len_reg)
                                begin
                                    gain_next    = '0;
                                    stage_next   = ST_DONE;
                                    elapsed_next = '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // quadrant folding: odd quadrants mirror the table, upper half negates
    logic [1:0]    s1_quad;
    logic [AW-1:0] s1_k;
    logic [AW-1:0] s1_k_eff;

    assign s1_quad  = s1_idx_reg[IDX_W-1 -: 2];
    assign s1_k     = s1_idx_reg[AW-1:0];
    assign s1_k_eff = s1_quad[0] ? ~s1_k : s1_k;

    // rounding half away from zero on the magnitude, then the sign
    logic [PROD_W-1:0]       round_sum;
    logic [SAMPLE_WIDTH-1:0] round_mag;
    logic [SAMPLE_WIDTH-1:0] signed_mag;

    assign round_sum  = s3_prod_reg + ROUND_HALF;
    assign round_mag  = round_sum[SHIFT +: SAMPLE_WIDTH];
    assign signed_mag = s3_neg_reg ? (~round_mag + 1'b1) : round_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg   <= ATTACK_LEN_RST;
            hold_len_reg     <= HOLD_LEN_RST;
            release_len_reg  <= RELEASE_LEN_RST;
            attack_step_reg  <= ATTACK_STEP_RST;
            release_step_reg <= RELEASE_STEP_RST;
            stage_reg        <= ST_IDLE;
            phase_acc_reg    <= '0;
            step_reg         <= '0;
            elapsed_reg      <= '0;
            gain_reg         <= '0;
            released_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_idx_reg       <= '0;
            s1_gain_reg      <= '0;
            s1_fin_reg       <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s2_mag_reg       <= '0;
            s2_neg_reg       <= 1'b0;
            s2_gain_reg      <= '0;
            s2_fin_reg       <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s3_prod_reg      <= '0;
            s3_neg_reg       <= 1'b0;
            s3_fin_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_sample_reg   <= '0;
            out_fin_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ATTACK_LEN:   attack_len_reg   <= cfg.data[LEN_W-1:0];
                    REG_HOLD_LEN:     hold_len_reg     <= cfg.data[LEN_W-1:0];
                    REG_RELEASE_LEN:  release_len_reg  <= cfg.data[LEN_W-1:0];
                    REG_ATTACK_STEP:  attack_step_reg  <= cfg.data[GAIN_W-1:0];
                    REG_RELEASE_STEP: release_step_reg <= cfg.data[GAIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            stage_reg     <= stage_next;
            phase_acc_reg <= phase_acc_next;
            step_reg      <= step_next;
            elapsed_reg   <= elapsed_next;
            gain_reg      <= gain_next;
            released_reg  <= released_next;

            // sample uses the phase before the step is added
            if (take1)
            begin
                s1_valid_reg <= tick_fire;
                s1_idx_reg   <= phase_acc_reg[PHASE_WIDTH-1 -: IDX_W];
                s1_gain_reg  <= sample_gain;
                s1_fin_reg   <= (stage_reg == ST_DONE);
            end

            if (take2)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_mag_reg   <= quarter_rom[s1_k_eff];
                s2_neg_reg   <= s1_quad[1];
                s2_gain_reg  <= s1_gain_reg;
                s2_fin_reg   <= s1_fin_reg;
            end

            if (take3)
            begin
                s3_valid_reg <= s2_valid_reg;
                s3_prod_reg  <= PROD_W'(s2_mag_reg) * PROD_W'(s2_gain_reg);
                s3_neg_reg   <= s2_neg_reg;
                s3_fin_reg   <= s2_fin_reg;
            end

            if (take_out)
            begin
                out_valid_reg  <= s3_valid_reg;
                out_sample_reg <= $signed(signed_mag);
                out_fin_reg    <= s3_fin_reg;
            end
        end
    end

    assign audio.valid    = out_valid_reg;
    assign audio.sample   = out_sample_reg;
    assign audio.finished = out_fin_reg;

    // a finished voice is silent
    a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
        audio.valid && audio.finished |-> audio.sample == '0)
        else $error("finished voice gave a nonzero sample");

    // gain stays within 0 .. 1.0
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_FULL)
        else $error("envelope gain above full scale");

    // the voice never goes back to idle, so idle means silent
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_IDLE |-> gain_reg == '0 && elapsed_reg == '0)
        else $error("idle voice holds gain or count");

    // only tick items produce samples
    a_no_result_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && events.command != CMD_TICK |=> !s1_valid_reg)
        else $error("non-tick item entered the sample pipeline");

    // release end leaves the voice done and silent
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_DONE |-> gain_reg == '0 && elapsed_reg == '0)
        else $error("done voice holds gain or count");

endmodule

>>> tb/sv/tb.sv
module tb;
    import svahr_pkg::*;

    // command 3 has no name in the package: the voice drops it without a result
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    localparam int QUARTER_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 8;     // margin for trailing items to clear the sample pipeline
    localparam int QUIET_LIMIT   = 1000;  // cycles with no handshake on any channel
    localparam int PHASE_ITEMS   = 70;

    typedef enum logic [2:0] {
        ENV_IDLE,
        ENV_ATTACK,
        ENV_HOLD,
        ENV_RELEASE,
        ENV_DONE
    } env_stage_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               finished;
    } voice_out_t;

    logic clk;
    logic rst_n;

    svahr_in_if                     ev();
    svahr_out_if #(.SAMPLE_WIDTH(16)) au();
    svahr_cfg_if                    cfg_bus();

    sine_voice_with_ahr_envelope dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (ev),
        .audio  (au),
        .cfg    (cfg_bus)
    );

    // envelope registers as the voice should hold them
    logic [LEN_W-1:0]  attack_len_r   = ATTACK_LEN_RST;
    logic [LEN_W-1:0]  hold_len_r     = HOLD_LEN_RST;
    logic [LEN_W-1:0]  release_len_r  = RELEASE_LEN_RST;
    logic [GAIN_W-1:0] attack_step_r  = ATTACK_STEP_RST;
    logic [GAIN_W-1:0] release_step_r = RELEASE_STEP_RST;

    // voice state mirror
    logic [31:0]       voice_phase     = '0;
    logic [31:0]       voice_inc       = '0;
    env_stage_t        voice_stage     = ENV_IDLE;
    logic [LEN_W-1:0]  stage_count     = '0;
    logic [GAIN_W-1:0] voice_gain      = '0;
    logic              release_pending = 1'b0;

    logic [31:0] sine_quarter [QUARTER_DEPTH];

    voice_out_t expected_samples[$];
    int         errors     = 0;
    int         items_sent = 0;
    bit         steady     = 1'b0;   // when set, no sender gaps and no sink stalls

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // q30 sine at the middle of quarter-wave bin k, truncated taylor series to x^11
    function automatic logic [31:0] quarter_point(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x    = (PI_HALF_Q30 * (64'(k) * 64'd2 + 64'd1)) / 64'(2 * QUARTER_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc[31:0];
    endfunction

    // half-scale sine times gain, rounded half away from zero
    function automatic logic [15:0] voice_sample(logic [31:0] ph, logic [GAIN_W-1:0] g);
        logic [11:0] bin;
        logic [9:0]  k;
        logic [63:0] mag;
        logic [63:0] rounded;
        bin = ph[31:20];
        k   = bin[9:0];
        // odd quadrants run the table backwards
        if (bin[10])
            k = ~k;
        mag     = 64'(sine_quarter[k]) * 64'(g);
        rounded = (mag + (64'd1 << 38)) >> 39;
        // lower half of the wave is negated
        if (bin[11])
            rounded = -rounded;
        return rounded[15:0];
    endfunction

    // one tick: sample from the current phase and gain, then step the envelope
    function automatic voice_out_t advance_voice();
        voice_out_t  r;
        logic [31:0] sum;
        r.sample   = '0;
        r.finished = 1'b0;
        if (voice_stage == ENV_DONE)
            r.finished = 1'b1;
        else if (voice_stage != ENV_IDLE)
        begin
            // release waits for both note off and the minimum hold
            if (voice_stage == ENV_HOLD && release_pending && stage_count >= hold_len_r)
            begin
                voice_stage = ENV_RELEASE;
                stage_count = '0;
                voice_gain  = GAIN_FULL;
            end
            r.sample    = voice_sample(voice_phase, voice_gain);
            voice_phase = voice_phase + voice_inc;
            if (stage_count != CNT_MAX)
                stage_count = stage_count + 1'b1;
            if (voice_stage == ENV_ATTACK)
            begin
                sum        = 32'(voice_gain) + 32'(attack_step_r);
                voice_gain = (sum > 32'(GAIN_FULL)) ? GAIN_FULL : sum[GAIN_W-1:0];
                // a zero length behaves as one sample
                if (stage_count >= attack_len_r)
                begin
                    voice_gain  = GAIN_FULL;
                    voice_stage = ENV_HOLD;
                    stage_count = '0;
                end
            end
            else if (voice_stage == ENV_RELEASE)
            begin
                voice_gain = (voice_gain > release_step_r) ? voice_gain - release_step_r : '0;
                if (stage_count >= release_len_r)
                begin
                    voice_gain  = '0;
                    voice_stage = ENV_DONE;
                    stage_count = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic void apply_event(logic [CMD_W-1:0] cmd, logic [31:0] inc);
        case (cmd)
            CMD_NOTE_ON:
            begin
                voice_phase     = '0;
                voice_inc       = inc;
                stage_count     = '0;
                voice_gain      = '0;
                voice_stage     = ENV_ATTACK;
                release_pending = 1'b0;
            end
            CMD_NOTE_OFF: release_pending = 1'b1;
            CMD_TICK:     expected_samples.push_back(advance_voice());
            default: ;
        endcase
    endfunction

    function automatic void check_sample(logic signed [15:0] s, logic f);
        voice_out_t want;
        if (expected_samples.size() == 0)
        begin
            $error("unexpected sample item: sample %0d finished %0b", s, f);
            errors++;
        end
        else
        begin
            want = expected_samples.pop_front();
            if (want.sample !== s)
            begin
                $error("sample: expected %0d, got %0d", want.sample, s);
                errors++;
            end
            if (want.finished !== f)
            begin
                $error("finished: expected %0b, got %0b", want.finished, f);
                errors++;
            end
        end
    endfunction

    // predict on accepted events first, then check accepted samples
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ev.valid && ev.ready)
                apply_event(ev.command, ev.phase_step);
            if (au.valid && au.ready)
                check_sample(au.sample, au.finished);
        end
    end

    // ------------------------------------------------------------------
    // audio sink: random stall before each item, none in steady stretches
    // ------------------------------------------------------------------
    initial
    begin : audio_sink
        int stall;
        au.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                au.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            au.ready <= 1'b1;
            do @(posedge clk); while (!au.valid);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no channel moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((ev.valid && ev.ready) || (au.valid && au.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one event item; valid stays high on return so back-to-back items need no bubble
    task automatic send_event(logic [CMD_W-1:0] cmd, logic [31:0] inc);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            ev.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev.valid      <= 1'b1;
        ev.command    <= cmd;
        ev.phase_step <= inc;
        do @(posedge clk); while (!ev.ready);
        if (cmd != CMD_IGNORED)
            items_sent++;
    endtask

    task automatic play_ticks(int n);
        repeat (n) send_event(CMD_TICK, $urandom);
    endtask

    // stop sending, let every sample come back, then give trailing items time to clear
    task automatic settle();
        ev.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg valid high; the caller lowers it after the last write of a batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_ATTACK_LEN:   attack_len_r   = val[LEN_W-1:0];
            REG_HOLD_LEN:     hold_len_r     = val[LEN_W-1:0];
            REG_RELEASE_LEN:  release_len_r  = val[LEN_W-1:0];
            REG_ATTACK_STEP:  attack_step_r  = val;
            REG_RELEASE_STEP: release_step_r = val;
            default: ;
        endcase
    endtask

    // full envelope setup while the voice pipeline is empty; lengths carry junk above bit 19
    task automatic load_envelope(logic [LEN_W-1:0] a_len, logic [LEN_W-1:0] h_len,
                                 logic [LEN_W-1:0] r_len, logic [GAIN_W-1:0] a_step,
                                 logic [GAIN_W-1:0] r_step, bit with_spare);
        settle();
        write_reg(REG_ATTACK_LEN,   {4'($urandom_range(0, 15)), a_len});
        write_reg(REG_HOLD_LEN,     {4'($urandom_range(0, 15)), h_len});
        write_reg(REG_RELEASE_LEN,  {4'($urandom_range(0, 15)), r_len});
        write_reg(REG_ATTACK_STEP,  a_step);
        write_reg(REG_RELEASE_STEP, r_step);
        // indexes past the last register must not disturb anything
        if (with_spare)
            for (int i = int'(REG_RELEASE_STEP) + 1; i < (1 << CFG_IDX_W); i++)
                write_reg(CFG_IDX_W'(i), 24'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // no note since reset: silent, not finished; note off and command 3 change nothing visible
    task automatic test_idle_voice();
        play_ticks(2);
        send_event(CMD_NOTE_OFF, 32'hFFFF_FFFF);
        send_event(CMD_IGNORED, $urandom);
        play_ticks(1);
    endtask

    // reset envelope values, top phase step, then a note on in the middle of a note
    task automatic test_reset_envelope();
        send_event(CMD_NOTE_ON, 32'hFFFF_FFFF);
        play_ticks(3);
        send_event(CMD_NOTE_ON, 32'h0000_0000);
        play_ticks(2);
    endtask

    // short envelope walked end to end: early note off, hold, release, finished,
    // note off on a finished voice, and a quarter turn per sample to visit every quadrant
    task automatic test_short_envelope();
        load_envelope(20'd2, 20'd1, 20'd2, 24'h400000, 24'h400000, 1'b0);
        send_event(CMD_NOTE_ON, 32'h4000_0000);
        send_event(CMD_NOTE_OFF, $urandom);
        play_ticks(7);
        send_event(CMD_NOTE_OFF, $urandom);
        play_ticks(1);
    endtask

    // zero lengths act as one; out-of-range steps clip; spare register indexes ignored
    task automatic test_zero_lengths();
        load_envelope(20'd0, 20'd0, 20'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_event(CMD_NOTE_ON, 32'h1234_5678);
        send_event(CMD_NOTE_OFF, $urandom);
        play_ticks(4);
    endtask

    task automatic random_envelope();
        logic [LEN_W-1:0]  a_len;
        logic [LEN_W-1:0]  h_len;
        logic [LEN_W-1:0]  r_len;
        logic [GAIN_W-1:0] a_step;
        logic [GAIN_W-1:0] r_step;
        a_len = LEN_W'($urandom_range(0, 12));
        h_len = LEN_W'($urandom_range(0, 6));
        r_len = LEN_W'($urandom_range(0, 12));
        case ($urandom_range(0, 3))
            0:       a_step = GAIN_W'(32'h800000 / ((a_len == 0) ? 32'd1 : 32'(a_len)));
            1:       a_step = GAIN_W'($urandom);
            2:       a_step = GAIN_FULL;
            default: a_step = GAIN_W'($urandom_range(0, 32'h100000));
        endcase
        case ($urandom_range(0, 3))
            0:       r_step = GAIN_W'(32'h800000 / ((r_len == 0) ? 32'd1 : 32'(r_len)));
            1:       r_step = GAIN_W'($urandom);
            2:       r_step = '0;
            default: r_step = GAIN_W'($urandom_range(0, 32'h100000));
        endcase
        load_envelope(a_len, h_len, r_len, a_step, r_step, 1'b0);
    endtask

    // mostly complete notes with random timing, some stray commands mixed in
    task automatic play_note();
        int          att;
        int          hld;
        int          rel;
        logic [31:0] inc;
        steady = ($urandom_range(0, 4) == 0);
        att = (attack_len_r > 16)  ? 16 : int'(attack_len_r);
        hld = (hold_len_r > 8)     ? 8  : int'(hold_len_r);
        rel = (release_len_r > 16) ? 16 : int'(release_len_r);
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 5))
                0:       inc = $urandom_range(0, 32'h400000);
                1:       inc = 32'hFFFF_FFFF;
                2:       inc = 32'h0;
                default: inc = $urandom;
            endcase
            send_event(CMD_NOTE_ON, inc);
            play_ticks($urandom_range(0, att + hld + 3));
            send_event(CMD_NOTE_OFF, $urandom);
            play_ticks($urandom_range(0, rel + 4));
        end
        else
            repeat ($urandom_range(1, 6))
                send_event(CMD_W'($urandom_range(0, 3)), $urandom);
    endtask

    // several envelope settings: shortest, longest, then random ones
    task automatic test_random_notes();
        int phase_end;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       load_envelope(20'd1, 20'd0, 20'd1, GAIN_FULL, GAIN_FULL, 1'b0);
                1:       load_envelope(CNT_MAX, CNT_MAX, CNT_MAX, 24'hFFFFFF, 24'h0, 1'b0);
                default: random_envelope();
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                play_note();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        ev.valid         <= 1'b0;
        ev.command       <= CMD_TICK;
        ev.phase_step    <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_ATTACK_LEN;
        cfg_bus.data     <= '0;
        for (int k = 0; k < QUARTER_DEPTH; k++)
            sine_quarter[k] = quarter_point(k);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_voice();
        test_reset_envelope();
        test_short_envelope();
        test_zero_lengths();
        test_random_notes();

        settle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
